### sv/v3alu_pkg.sv
// ---------------------------------------------------------------------------
// v3alu_pkg
// Opcodes, status codes and the saturation helper shared by the vector unit.
// ---------------------------------------------------------------------------
package v3alu_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_NEG   = 4'd2;
    localparam logic [3:0] OP_SCALE = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_DOT   = 4'd5;
    localparam logic [3:0] OP_CROSS = 4'd6;
    localparam logic [3:0] OP_LEN   = 4'd7;
    localparam logic [3:0] OP_NORM  = 4'd8;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_sat;

    function automatic t_sat f_sat(input logic signed [65:0] v);
        t_sat s;
        s.ovf = 1'b0;
        s.val = v[31:0];
        if (v > 66'(S32_MAX)) begin
            s.ovf = 1'b1;
            s.val = S32_MAX;
        end else if (v < 66'(S32_MIN)) begin
            s.ovf = 1'b1;
            s.val = S32_MIN;
        end
        return s;
    endfunction

endpackage

### sv/v3alu_lane.sv
// ---------------------------------------------------------------------------
// v3alu_lane
// One component lane: two products, then add/sub/neg/scale/cross with
// saturation; hands floored product and square on to the merge stage.
// ---------------------------------------------------------------------------
module v3alu_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [3:0]            i_op,
    input  logic signed [31:0]    i_ai,
    input  logic signed [31:0]    i_aj,
    input  logic signed [31:0]    i_ak,
    input  logic signed [31:0]    i_bi,
    input  logic signed [31:0]    i_bj,
    input  logic signed [31:0]    i_bk,
    input  logic signed [31:0]    i_s,
    output v3alu_pkg::t_sat       o_res,
    output logic signed [63:0]    o_fa,
    output logic [63:0]           o_sq
);

    logic signed [31:0] ml, mr;
    logic signed [63:0] r_pa, r_pb;
    logic [3:0]         r_op;
    logic signed [31:0] r_ai, r_bi;
    logic signed [63:0] fa, fb;
    v3alu_pkg::t_sat    n_res;
    v3alu_pkg::t_sat    r_res;
    logic signed [63:0] r_fa;
    logic [63:0]        r_sq;

    always_comb begin
        case (i_op)
            v3alu_pkg::OP_SCALE: begin
                ml = i_ai;
                mr = i_s;
            end
            v3alu_pkg::OP_CROSS: begin
                ml = i_aj;
                mr = i_bk;
            end
            v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM: begin
                ml = i_ai;
                mr = i_ai;
            end
            default: begin
                ml = i_ai;
                mr = i_bi;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= ml * mr;
            r_pb <= i_ak * i_bj;
            r_op <= i_op;
            r_ai <= i_ai;
            r_bi <= i_bi;
        end
    end

    // floor shift of the products
    assign fa = r_pa >>> FRAC_BITS;
    assign fb = r_pb >>> FRAC_BITS;

    always_comb begin
        n_res = '0;
        case (r_op)
            v3alu_pkg::OP_ADD:   n_res = v3alu_pkg::f_sat(66'(r_ai) + 66'(r_bi));
            v3alu_pkg::OP_SUB:   n_res = v3alu_pkg::f_sat(66'(r_ai) - 66'(r_bi));
            v3alu_pkg::OP_NEG:   n_res = v3alu_pkg::f_sat(-66'(r_ai));
            v3alu_pkg::OP_SCALE: n_res = v3alu_pkg::f_sat(66'(fa));
            v3alu_pkg::OP_CROSS: n_res = v3alu_pkg::f_sat(66'(fa) - 66'(fb));
            default:             n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_fa  <= fa;
            r_sq  <= $unsigned(r_pa);
        end
    end

    assign o_res = r_res;
    assign o_fa  = r_fa;
    assign o_sq  = r_sq;

endmodule

### sv/v3alu_merge.sv
// ---------------------------------------------------------------------------
// v3alu_merge
// Combines the three lanes: saturated dot product and sum of squares.
// ---------------------------------------------------------------------------
module v3alu_merge (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [63:0]    i_fa [3],
    input  logic [63:0]           i_sq [3],
    output v3alu_pkg::t_sat       o_dot,
    output logic [63:0]           o_sumsq
);

    logic signed [65:0] dot;
    v3alu_pkg::t_sat    r_dot;
    logic [63:0]        r_sumsq;

    assign dot = 66'(i_fa[0]) + 66'(i_fa[1]) + 66'(i_fa[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot   <= v3alu_pkg::f_sat(dot);
            // three squares of 32-bit values cannot reach 2^64
            r_sumsq <= i_sq[0] + i_sq[1] + i_sq[2];
        end
    end

    assign o_dot   = r_dot;
    assign o_sumsq = r_sumsq;

endmodule

### sv/v3alu_sqrt.sv
// ---------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ---------------------------------------------------------------------------
module v3alu_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_n,
    output logic [31:0] o_root
);

    localparam int STEPS = 32;

    logic [63:0] r_n   [STEPS];
    logic [63:0] r_res [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] p_n, p_res, n_n, n_res;
        logic [64:0] trial;

        if (k == 0) begin : g_first
            assign p_n   = i_n;
            assign p_res = '0;
        end else begin : g_next
            assign p_n   = r_n[k-1];
            assign p_res = r_res[k-1];
        end

        always_comb begin
            trial = 65'(p_res) + 65'(BIT);
            if (65'(p_n) >= trial) begin
                n_n   = p_n - trial[63:0];
                n_res = (p_res >> 1) + BIT;
            end else begin
                n_n   = p_n;
                n_res = p_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]   <= n_n;
                r_res[k] <= n_res;
            end
        end
    end

    assign o_root = r_res[STEPS-1][31:0];

endmodule

### sv/v3alu_div.sv
// ---------------------------------------------------------------------------
// v3alu_div
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// ---------------------------------------------------------------------------
module v3alu_div #(
    parameter int W = 48
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_num,
    input  logic [31:0]   i_den,
    output logic [W-1:0]  o_quo
);

    logic [31:0]  r_rem [W];
    logic [W-1:0] r_num [W];
    logic [W-1:0] r_quo [W];
    logic [31:0]  r_den [W];

    for (genvar j = 0; j < W; j++) begin : g_step
        logic [31:0]  p_rem, p_den, n_rem;
        logic [W-1:0] p_num, p_quo;
        logic [32:0]  trial;
        logic         qbit;

        if (j == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[j-1];
            assign p_num = r_num[j-1];
            assign p_quo = r_quo[j-1];
            assign p_den = r_den[j-1];
        end

        always_comb begin
            trial = {p_rem, p_num[W-1]};
            if (trial >= {1'b0, p_den}) begin
                qbit  = 1'b1;
                n_rem = 32'(trial - {1'b0, p_den});
            end else begin
                qbit  = 1'b0;
                n_rem = trial[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_num[j] <= {p_num[W-2:0], 1'b0};
                r_quo[j] <= {p_quo[W-2:0], qbit};
                r_den[j] <= p_den;
            end
        end
    end

    assign o_quo = r_quo[W-1];

endmodule

### sv/vec3_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// vec3_arithmetic_unit
// Three-component Q-format vector unit: add, sub, neg, scale, divide, dot,
// cross, length and normalize, saturating, with a status code per result.
//
//   channel  | valid    | ready    | payload
//   ---------+----------+----------+---------------------------------------
//   input    | i_valid  | o_ready  | i_op, i_ax..i_bz, i_scalar_in
//   output   | o_valid  | i_ready  | o_rx, o_ry, o_rz, o_scalar_out, o_status
//
// Every opcode passes through the whole pipeline, whose depth is set by the
// 32-stage square root followed by the one-bit-per-stage divider. One beat
// is taken every cycle while the output side keeps up.
// The whole pipeline holds when the output register is full and not taken;
// o_ready follows that. Reset clears the valid bits only.
// ---------------------------------------------------------------------------
module vec3_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_op,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by_comp,
    input  logic signed [31:0] i_bz,
    input  logic signed [31:0] i_scalar_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic signed [31:0] o_rz,
    output logic signed [31:0] o_scalar_out,
    output logic [1:0]         o_status
);

    localparam int W      = 32 + FRAC_BITS;
    localparam int ST_SQ  = 35;
    localparam int ST_LEN = ST_SQ + 1;
    localparam int LAST   = ST_SQ + W;
    localparam int DEPTH  = LAST + 1;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] a;
        logic [31:0]      s;
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic             ovf;
        logic [31:0]      root;
    } t_side;

    logic               adv, in_acc;
    logic [DEPTH:1]     r_vld;
    t_side              r_side [1:LAST];
    t_side              n_s1, n_s3, n_s4, n_slen, sd;

    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    v3alu_pkg::t_sat    lane_res [3];
    logic signed [63:0] lane_fa  [3];
    logic [63:0]        lane_sq  [3];
    v3alu_pkg::t_sat    dot;
    logic [63:0]        sumsq;
    logic [31:0]        root;
    logic [31:0]        den;
    logic [W-1:0]       quo [3];

    logic signed [31:0] n_r [3];
    logic [2:0]         n_ovf;
    logic               n_dz;
    logic [1:0]         n_status;
    logic signed [31:0] r_r [3];
    logic signed [31:0] r_sc;
    logic [1:0]         r_status;

    assign adv     = !r_vld[DEPTH] || i_ready;
    assign o_ready = adv;
    assign in_acc  = i_valid && adv;

    assign va[0] = i_ax;
    assign va[1] = i_ay;
    assign va[2] = i_az;
    assign vb[0] = i_bx;
    assign vb[1] = i_by_comp;
    assign vb[2] = i_bz;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_op  (i_op),
            .i_ai  (va[g]),
            .i_aj  (va[(g+1)%3]),
            .i_ak  (va[(g+2)%3]),
            .i_bi  (vb[g]),
            .i_bj  (vb[(g+1)%3]),
            .i_bk  (vb[(g+2)%3]),
            .i_s   (i_scalar_in),
            .o_res (lane_res[g]),
            .o_fa  (lane_fa[g]),
            .o_sq  (lane_sq[g])
        );
    end

    v3alu_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_fa    (lane_fa),
        .i_sq    (lane_sq),
        .o_dot   (dot),
        .o_sumsq (sumsq)
    );

    v3alu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_n    (sumsq),
        .o_root (root)
    );

    // divisor: |s| for divide, the full-width length for normalize
    always_comb begin
        if (r_side[ST_SQ].op == v3alu_pkg::OP_DIV) begin
            den = r_side[ST_SQ].s[31] ? (~r_side[ST_SQ].s + 32'd1) : r_side[ST_SQ].s;
        end else begin
            den = root;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        logic [31:0] mag;
        assign mag = r_side[ST_SQ].a[g][31] ? (~r_side[ST_SQ].a[g] + 32'd1)
                                            : r_side[ST_SQ].a[g];
        v3alu_div #(.W(W)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num ({mag, {FRAC_BITS{1'b0}}}),
            .i_den (den),
            .o_quo (quo[g])
        );
    end

    // side data travelling alongside the arithmetic
    always_comb begin
        n_s1      = '0;
        n_s1.op   = i_op;
        n_s1.a    = {i_az, i_ay, i_ax};
        n_s1.s    = i_scalar_in;

        n_s3      = r_side[2];
        n_s3.r    = {lane_res[2].val, lane_res[1].val, lane_res[0].val};
        n_s3.ovf  = lane_res[0].ovf | lane_res[1].ovf | lane_res[2].ovf;

        n_s4      = r_side[3];
        if (r_side[3].op == v3alu_pkg::OP_DOT) begin
            n_s4.sc  = dot.val;
            n_s4.ovf = r_side[3].ovf | dot.ovf;
        end

        n_slen      = r_side[ST_SQ];
        n_slen.root = root;
        if (r_side[ST_SQ].op == v3alu_pkg::OP_LEN) begin
            if (root[31]) begin
                n_slen.sc  = v3alu_pkg::S32_MAX;
                n_slen.ovf = 1'b1;
            end else begin
                n_slen.sc = root;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-1:1], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[1] <= n_s1;
            for (int k = 2; k <= LAST; k++) begin
                if (k == 3) begin
                    r_side[k] <= n_s3;
                end else if (k == 4) begin
                    r_side[k] <= n_s4;
                end else if (k == ST_LEN) begin
                    r_side[k] <= n_slen;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    // final assembly: quotients, divide by zero and zero-length normalize
    assign sd = r_side[LAST];

    always_comb begin
        logic signed [65:0] qs;
        v3alu_pkg::t_sat    sat;
        n_dz = 1'b0;
        sat  = '0;
        for (int i = 0; i < 3; i++) begin
            n_r[i]   = sd.r[i];
            n_ovf[i] = 1'b0;
            qs       = $signed(66'(quo[i]));
            case (sd.op)
                v3alu_pkg::OP_DIV: begin
                    if (sd.s == '0) begin
                        n_dz = 1'b1;
                        if (sd.a[i] == '0) begin
                            n_r[i] = '0;
                        end else if (sd.a[i][31]) begin
                            n_r[i] = v3alu_pkg::S32_MIN;
                        end else begin
                            n_r[i] = v3alu_pkg::S32_MAX;
                        end
                    end else begin
                        sat      = v3alu_pkg::f_sat((sd.a[i][31] ^ sd.s[31]) ? -qs : qs);
                        n_r[i]   = sat.val;
                        n_ovf[i] = sat.ovf;
                    end
                end
                v3alu_pkg::OP_NORM: begin
                    if (sd.root == '0) begin
                        n_r[i] = sd.a[i];
                    end else begin
                        sat      = v3alu_pkg::f_sat(sd.a[i][31] ? -qs : qs);
                        n_r[i]   = sat.val;
                        n_ovf[i] = sat.ovf;
                    end
                end
                default: n_r[i] = sd.r[i];
            endcase
        end
        if (n_dz) begin
            n_status = v3alu_pkg::ST_DZ;
        end else if (sd.ovf || (|n_ovf)) begin
            n_status = v3alu_pkg::ST_SAT;
        end else begin
            n_status = v3alu_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r[0]   <= n_r[0];
            r_r[1]   <= n_r[1];
            r_r[2]   <= n_r[2];
            r_sc     <= sd.sc;
            r_status <= n_status;
        end
    end

    assign o_valid      = r_vld[DEPTH];
    assign o_rx         = r_r[0];
    assign o_ry         = r_r[1];
    assign o_rz         = r_r[2];
    assign o_scalar_out = r_sc;
    assign o_status     = r_status;

endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the vector unit: directed corner beats for every
// opcode, then random beats, checked in order against a behavioural predictor.
// ---------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int TIMEOUT_CYCLES = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [31:0] rx, ry, rz, sc;
        logic [1:0]         st;
    } t_vec_result;

    logic               i_clk, i_rst_n, i_valid, i_ready;
    logic               o_ready, o_valid;
    logic [3:0]         i_op;
    logic signed [31:0] i_ax, i_ay, i_az, i_bx, i_by_comp, i_bz, i_scalar_in;
    logic signed [31:0] o_rx, o_ry, o_rz, o_scalar_out;
    logic [1:0]         o_status;

    t_vec_result expected_q[$];
    int  mismatches = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  idle_cycles = 0;
    bit  no_idle = 0;

    vec3_arithmetic_unit #(.FRAC_BITS(FRAC)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [127:0] v,
                                                   inout bit ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1;
            return 64'sd2147483647;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1;
            return -64'sd2147483648;
        end
        return v[63:0];
    endfunction

    // arithmetic shift floors
    function automatic logic signed [127:0] mul_floor(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return p >>> FRAC;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [127:0] n);
        logic [127:0] r, lo, hi, mid;
        lo = 0;
        hi = 128'h1_0000_0000_0000_0000;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid;
        end
        r = lo;
        return r[63:0];
    endfunction

    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] num,
                                                      input logic [127:0] den,
                                                      input bit den_neg);
        logic [127:0] m, q;
        m = num < 0 ? -num : num;
        q = (m << FRAC) / den;
        return ((num < 0) != den_neg) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_vec_result predict_vec(input logic [3:0] op,
        input logic signed [31:0] a[3], input logic signed [31:0] b[3],
        input logic signed [31:0] s);
        t_vec_result res;
        logic signed [127:0] r[3];
        logic signed [127:0] sc;
        logic [127:0] sumsq, len, smag;
        bit ovf;
        ovf = 0;
        r = '{0, 0, 0};
        sc = 0;
        res.st = v3alu_pkg::ST_OK;
        sumsq = 0;
        for (int i = 0; i < 3; i++) sumsq += 128'(a[i]) * 128'(a[i]);
        len = int_sqrt(sumsq);
        smag = s < 0 ? -128'(s) : 128'(s);
        case (op)
            v3alu_pkg::OP_ADD:
                for (int i = 0; i < 3; i++) r[i] = clamp32(128'(a[i]) + b[i], ovf);
            v3alu_pkg::OP_SUB:
                for (int i = 0; i < 3; i++) r[i] = clamp32(128'(a[i]) - b[i], ovf);
            v3alu_pkg::OP_NEG:
                for (int i = 0; i < 3; i++) r[i] = clamp32(-128'(a[i]), ovf);
            v3alu_pkg::OP_SCALE:
                for (int i = 0; i < 3; i++) r[i] = clamp32(mul_floor(a[i], s), ovf);
            v3alu_pkg::OP_DIV: begin
                if (s == 0) begin
                    for (int i = 0; i < 3; i++)
                        r[i] = a[i] > 0 ? 128'sd2147483647 :
                               (a[i] < 0 ? -128'sd2147483648 : 128'sd0);
                    res.st = v3alu_pkg::ST_DZ;
                end else begin
                    for (int i = 0; i < 3; i++)
                        r[i] = clamp32(trunc_div(a[i], smag, s < 0), ovf);
                end
            end
            v3alu_pkg::OP_DOT: sc = clamp32(mul_floor(a[0], b[0]) + mul_floor(a[1], b[1])
                                            + mul_floor(a[2], b[2]), ovf);
            v3alu_pkg::OP_CROSS: begin
                r[0] = clamp32(mul_floor(a[1], b[2]) - mul_floor(a[2], b[1]), ovf);
                r[1] = clamp32(mul_floor(a[2], b[0]) - mul_floor(a[0], b[2]), ovf);
                r[2] = clamp32(mul_floor(a[0], b[1]) - mul_floor(a[1], b[0]), ovf);
            end
            v3alu_pkg::OP_LEN: sc = clamp32($signed(len), ovf);
            v3alu_pkg::OP_NORM: begin
                if (len == 0) for (int i = 0; i < 3; i++) r[i] = a[i];
                else for (int i = 0; i < 3; i++)
                    r[i] = clamp32(trunc_div(a[i], len, 1'b0), ovf);
            end
            default: ;
        endcase
        if (res.st == v3alu_pkg::ST_OK && ovf) res.st = v3alu_pkg::ST_SAT;
        res.rx = r[0][31:0];
        res.ry = r[1][31:0];
        res.rz = r[2][31:0];
        res.sc = sc[31:0];
        return res;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 23);
    endfunction

    task automatic send_beat(input logic [3:0] op, input logic signed [31:0] a[3],
                             input logic signed [31:0] b[3], input logic signed [31:0] s);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_ax        <= a[0];
        i_ay        <= a[1];
        i_az        <= a[2];
        i_bx        <= b[0];
        i_by_comp   <= b[1];
        i_bz        <= b[2];
        i_scalar_in <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(predict_vec(op, a, b, s));
        beats_sent++;
    endtask

    function automatic logic signed [31:0] corner_val();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return 32'sh00010000;
            4: return -32'sh00010000;
            5: return $signed($urandom_range(255)) - 128;
            6: return 32'sh40000000;
            7: return $signed(32'($urandom)) >>> $urandom_range(31);
            default: return $signed(32'($urandom));
        endcase
    endfunction

    // output side: random stall on i_ready, check each beat in order
    always @(posedge i_clk) begin
        t_vec_result exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: got %h %h %h sc %h st %0d",
                                 o_rx, o_ry, o_rz, o_scalar_out, o_status);
                end else begin
                    exp_r = expected_q.pop_front();
                    beats_checked++;
                    if (o_rx !== exp_r.rx || o_ry !== exp_r.ry || o_rz !== exp_r.rz ||
                        o_scalar_out !== exp_r.sc || o_status !== exp_r.st) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("exp %h %h %h sc %h st %0d, got %h %h %h sc %h st %0d",
                                     exp_r.rx, exp_r.ry, exp_r.rz, exp_r.sc, exp_r.st,
                                     o_rx, o_ry, o_rz, o_scalar_out, o_status);
                    end
                end
            end
            i_ready <= !idle_now();
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= TIMEOUT_CYCLES) begin
            $display("** vec3_arithmetic_unit: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic signed [31:0] a[3], b[3];
        logic [3:0] op;
        for (int k = 0; k < 25; k++) begin
            op = 4'(k % 16);
            case (k / 16)
                0: begin
                    a = '{32'sh7fffffff, 32'sh80000000, 32'sh00010000};
                    b = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
                end
                default: begin
                    a = '{0, 0, 0};
                    b = '{32'sh80000000, 0, 32'sh7fffffff};
                end
            endcase
            send_beat(op, a, b, (k % 3 == 0) ? 32'sh0 : 32'sh80000000);
        end
        // divide by zero with mixed signs and normalize of a zero vector
        send_beat(v3alu_pkg::OP_DIV, '{5, -5, 0}, b, 0);
        send_beat(v3alu_pkg::OP_NORM, '{0, 0, 0}, b, 0);
        send_beat(v3alu_pkg::OP_DIV, '{32'sh80000000, 32'sh7fffffff, 1}, b, 1);
        send_beat(v3alu_pkg::OP_NEG, '{32'sh80000000, 1, -1}, b, 0);
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] a[3], b[3], s;
        logic [3:0] op;
        for (int k = 0; k < count; k++) begin
            no_idle = (k >= count / 3 && k < count / 3 + 150);
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                            : 4'($urandom_range(8));
            for (int i = 0; i < 3; i++) begin
                a[i] = corner_val();
                b[i] = corner_val();
            end
            s = corner_val();
            send_beat(op, a, b, s);
        end
        no_idle = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = '0;
        {i_ax, i_ay, i_az, i_bx, i_by_comp, i_bz, i_scalar_in} = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(1570);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d beats over all opcodes, %0d results checked",
                 beats_sent, beats_checked);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("** vec3_arithmetic_unit: PASSED **");
        end else begin
            $display("** vec3_arithmetic_unit: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
sv/v3alu_pkg.sv
sv/v3alu_lane.sv
sv/v3alu_merge.sv
sv/v3alu_sqrt.sv
sv/v3alu_div.sv
sv/vec3_arithmetic_unit.sv
dv/tb.sv
